@@ design/nrc_pkg.sv @@
// Shared types and constants for the row-major index converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nrc_pkg;

  localparam int unsigned IDX_W  = 32;
  localparam int unsigned SIZE_W = 8;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned REG_W  = 3;
  localparam int unsigned STEP_BITS = 8;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_COUNT = 2'd1,
    ST_RANGE = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  typedef enum logic [REG_W-1:0] {
    REG_NUM_DIMS = 3'd0,
    REG_SIZE_D0  = 3'd1,
    REG_SIZE_D1  = 3'd2,
    REG_SIZE_D2  = 3'd3,
    REG_SIZE_D3  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                         valid;
    logic                         op;
    logic [CNT_W-1:0]             n;
    logic [CNT_W-1:0]             cnt;
    logic                         scalar;
    logic                         zero;
    logic [3:1][SIZE_W-1:0]       m;
    logic [3:1][IDX_W-1:0]        a;
    logic [IDX_W-1:0]             acc;
    logic [IDX_W-1:0]             prod;
    logic [IDX_W-1:0]             w;
    logic [SIZE_W-1:0]            rem;
    logic [3:1][SIZE_W-1:0]       r;
  } item_t;

endpackage
`default_nettype wire

@@ design/nrc_horner_stage.sv @@
// One Horner step: acc*m + a, and the running size product.
// Depends on nrc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrc_horner_stage (
  input  wire logic [nrc_pkg::IDX_W-1:0]  acc_in,
  input  wire logic [nrc_pkg::IDX_W-1:0]  prod_in,
  input  wire logic [nrc_pkg::SIZE_W-1:0] mult,
  input  wire logic [nrc_pkg::IDX_W-1:0]  addend,
  output logic      [nrc_pkg::IDX_W-1:0]  acc_out,
  output logic      [nrc_pkg::IDX_W-1:0]  prod_out
);
  import nrc_pkg::*;

  logic [IDX_W+SIZE_W-1:0] acc_mul;
  logic [IDX_W+SIZE_W-1:0] prod_mul;

  always_comb begin
    acc_mul  = acc_in * mult;
    prod_mul = prod_in * mult;
    acc_out  = acc_mul[IDX_W-1:0] + addend;
    prod_out = prod_mul[IDX_W-1:0];
  end

endmodule
`default_nettype wire

@@ design/nrc_div_stage.sv @@
// Eight restoring-division steps of a 32-bit word by an 8-bit divisor.
// Depends on nrc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrc_div_stage (
  input  wire logic [nrc_pkg::IDX_W-1:0]  w_in,
  input  wire logic [nrc_pkg::SIZE_W-1:0] rem_in,
  input  wire logic [nrc_pkg::SIZE_W-1:0] divisor,
  output logic      [nrc_pkg::IDX_W-1:0]  w_out,
  output logic      [nrc_pkg::SIZE_W-1:0] rem_out
);
  import nrc_pkg::*;

  logic [IDX_W-1:0]  w;
  logic [SIZE_W-1:0] r;
  logic [SIZE_W:0]   t;

  // w shifts dividend bits out at the top and quotient bits in at the bottom
  always_comb begin
    w = w_in;
    r = rem_in;
    t = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, w[IDX_W-1]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
        w = {w[IDX_W-2:0], 1'b1};
      end else begin
        w = {w[IDX_W-2:0], 1'b0};
      end
      r = t[SIZE_W-1:0];
    end
    w_out   = w;
    rem_out = r;
  end

endmodule
`default_nettype wire

@@ design/nd_row_major_index_convert.sv @@
// Row-major index converter, up to four dimensions. A start beat passes the capture
// register, the stage registers and the output register before done strobes;
// throughput one item per clock, busy stays low. Twelve division stages (three
// 32-by-8 divisions, 8 quotient bits per stage) set the depth. The receiver cannot
// stall. Synchronous reset clears the pipeline valid bits and restores the size registers.
`timescale 1ns / 1ps
`default_nettype none
module nd_row_major_index_convert #(
  parameter int unsigned MAX_DIMS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  output logic                               done,
  input  wire logic                          cfg_we,
  input  wire logic [nrc_pkg::REG_W-1:0]     cfg_idx,
  input  wire logic [nrc_pkg::SIZE_W-1:0]    cfg_wdata,
  input  wire logic                          op,
  input  wire logic [nrc_pkg::CNT_W-1:0]     coord_count,
  input  wire logic [nrc_pkg::IDX_W-1:0]     coord_a,
  input  wire logic [nrc_pkg::IDX_W-1:0]     coord_b,
  input  wire logic [nrc_pkg::IDX_W-1:0]     coord_c,
  input  wire logic [nrc_pkg::IDX_W-1:0]     coord_e,
  input  wire logic [nrc_pkg::IDX_W-1:0]     flat_in,
  output logic      [nrc_pkg::IDX_W-1:0]     flat_out,
  output logic      [nrc_pkg::IDX_W-1:0]     out_a,
  output logic      [nrc_pkg::IDX_W-1:0]     out_b,
  output logic      [nrc_pkg::IDX_W-1:0]     out_c,
  output logic      [nrc_pkg::IDX_W-1:0]     out_e,
  output logic      [1:0]                    status
);
  import nrc_pkg::*;

  localparam int unsigned LIM      = (MAX_DIMS < 4) ? MAX_DIMS : 4;
  localparam int unsigned NSTAGES  = 3 * (IDX_W / STEP_BITS);
  localparam int unsigned PER_DIV  = IDX_W / STEP_BITS;

  logic [CNT_W-1:0]  num_dims;
  logic [SIZE_W-1:0] size_d0, size_d1, size_d2, size_d3;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= 3'd1;
      size_d0  <= 8'd0;
      size_d1  <= 8'd1;
      size_d2  <= 8'd1;
      size_d3  <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_NUM_DIMS: num_dims <= cfg_wdata[CNT_W-1:0];
        REG_SIZE_D0:  size_d0  <= cfg_wdata;
        REG_SIZE_D1:  size_d1  <= cfg_wdata;
        REG_SIZE_D2:  size_d2  <= cfg_wdata;
        REG_SIZE_D3:  size_d3  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // capture: decode config per beat
  logic [CNT_W-1:0] n;
  item_t cap;

  always_comb begin
    n = (num_dims > CNT_W'(LIM)) ? CNT_W'(LIM) : num_dims;
    cap = '0;
    cap.valid  = start && !busy;
    cap.op     = op;
    cap.n      = n;
    cap.cnt    = coord_count;
    cap.scalar = (coord_count == '0) && (n == 3'd1) && (size_d0 == 8'd1);
    cap.zero   = ((n >= 3'd1) && (size_d0 == '0)) || ((n >= 3'd2) && (size_d1 == '0)) ||
                 ((n >= 3'd3) && (size_d2 == '0)) || ((n >= 3'd4) && (size_d3 == '0));
    cap.m[1]   = (n >= 3'd2) ? size_d1 : 8'd1;
    cap.m[2]   = (n >= 3'd3) ? size_d2 : 8'd1;
    cap.m[3]   = (n >= 3'd4) ? size_d3 : 8'd1;
    cap.a[1]   = (n >= 3'd2) ? coord_b : '0;
    cap.a[2]   = (n >= 3'd3) ? coord_c : '0;
    cap.a[3]   = (n >= 3'd4) ? coord_e : '0;
    cap.acc    = (n >= 3'd1) ? coord_a : '0;
    cap.prod   = (n >= 3'd1) ? {{(IDX_W-SIZE_W){1'b0}}, size_d0} : '0;
    cap.w      = flat_in;
    cap.rem    = '0;
    cap.r      = '0;
  end

  item_t pipe [0:NSTAGES];

  always_ff @(posedge clk) begin
    if (rst) pipe[0] <= '0;
    else     pipe[0] <= cap;
  end

  for (genvar k = 1; k <= NSTAGES; k++) begin : g_stage
    localparam int unsigned SEL   = 3 - (k - 1) / PER_DIV;
    localparam bit          FIRST = ((k - 1) % PER_DIV) == 0;
    localparam bit          LAST  = (k % PER_DIV) == 0;

    item_t            nxt;
    logic [IDX_W-1:0] w_q;
    logic [SIZE_W-1:0] rem_q;

    nrc_div_stage u_div (
      .w_in    (pipe[k-1].w),
      .rem_in  (FIRST ? '0 : pipe[k-1].rem),
      .divisor (pipe[k-1].m[SEL]),
      .w_out   (w_q),
      .rem_out (rem_q)
    );

    if (k <= 3) begin : g_horner
      logic [IDX_W-1:0] acc_q, prod_q;
      nrc_horner_stage u_hor (
        .acc_in   (pipe[k-1].acc),
        .prod_in  (pipe[k-1].prod),
        .mult     (pipe[k-1].m[k]),
        .addend   (pipe[k-1].a[k]),
        .acc_out  (acc_q),
        .prod_out (prod_q)
      );
      always_comb begin
        nxt      = pipe[k-1];
        nxt.w    = w_q;
        nxt.rem  = rem_q;
        if (LAST) nxt.r[SEL] = rem_q;
        nxt.acc  = acc_q;
        nxt.prod = prod_q;
      end
    end else begin : g_plain
      always_comb begin
        nxt     = pipe[k-1];
        nxt.w   = w_q;
        nxt.rem = rem_q;
        if (LAST) nxt.r[SEL] = rem_q;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) pipe[k] <= '0;
      else     pipe[k] <= nxt;
    end
  end

  item_t   fin;
  status_t st_next;

  always_comb begin
    fin = pipe[NSTAGES];
    st_next = ST_OK;
    if (!fin.op) begin
      if (fin.scalar)                st_next = ST_OK;
      else if (fin.cnt != fin.n)     st_next = ST_COUNT;
      else if (fin.acc >= fin.prod)  st_next = ST_RANGE;
      else                           st_next = ST_OK;
    end else begin
      st_next = fin.zero ? ST_ZERO : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    status   <= st_next;
    flat_out <= (!fin.op && !fin.scalar && st_next == ST_OK) ? fin.acc : '0;
    if (fin.op && !fin.zero) begin
      out_a <= (fin.n >= 3'd1) ? fin.w : '0;
      out_b <= {{(IDX_W-SIZE_W){1'b0}}, fin.r[1]};
      out_c <= {{(IDX_W-SIZE_W){1'b0}}, fin.r[2]};
      out_e <= {{(IDX_W-SIZE_W){1'b0}}, fin.r[3]};
    end else begin
      out_a <= '0;
      out_b <= '0;
      out_c <= '0;
      out_e <= '0;
    end
    if (rst) done <= 1'b0;
    else     done <= fin.valid;
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##14 done)
    else $error("start beat without result");
  a_zero_clear: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_ZERO) |-> (out_a == '0 && out_b == '0 && out_c == '0 &&
                                     out_e == '0 && flat_out == '0))
    else $error("zero-size result carries coordinates");
  a_flat_ok: assert property (@(posedge clk) disable iff (rst)
    (done && flat_out != '0) |-> (status == ST_OK && out_a == '0))
    else $error("flat index with error status or coordinates");
`endif

endmodule
`default_nettype wire
